// ===== hw/rtl/atuv_pkg.sv =====
// shared types, constants and elaboration-time sine tables for the angle pair to vector block
`default_nettype none

package atuv_pkg;

	localparam int TABLE_SIZE   = 4096;
	localparam int FRAC_BITS    = 14;
	localparam int QUARTER      = TABLE_SIZE / 4;
	localparam int QUARTER2     = 2 * QUARTER;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int DEG_TURN = 360;
	localparam int DEG_HALF = 180;
	localparam int DEG_QUAD = 90;

	// 92 turns: any 16-bit angle plus this bias is non-negative and keeps its residue
	localparam logic [16:0] DEG_BIAS    = 17'd33120;
	// ceil(2^24 / 360), exact quotient for dividends up to 65887, which covers the biased range
	localparam logic [15:0] RECIP_360   = 16'd46604;
	localparam int          RECIP_SHIFT = 24;

	localparam logic signed [31:0] MUL_ROUND = 32'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [17:0] ONE_Q     = 18'sd1 <<< FRAC_BITS;

	typedef logic signed [15:0] fix_t;
	typedef logic [8:0] deg_t;

	localparam fix_t ONE_FIX = fix_t'(ONE_Q);

	typedef struct packed {
		logic signed [15:0] yaw_deg;
		logic signed [15:0] pitch_deg;
	} ang_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} vec_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	typedef fix_t half_tab_t [DEG_HALF];

	// sin over the first quadrant in q30, r counts table steps
	// ten taylor terms: x, then term k for k 1..9 divided by (2k)(2k+1)
	function automatic longint quarter_sine_q30(longint unsigned r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint acc;
		x = (64'd2 * HALF_PI_Q30 * r + QUARTER) / QUARTER2;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;
		acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;
		acc = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;
		acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;
		acc = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd110;
		acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd156;
		acc = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd210;
		acc = acc - longint'(term);
		term = ((term * x2) >> 30) / 64'd272;
		acc = acc + longint'(term);
		term = ((term * x2) >> 30) / 64'd342;
		acc = acc - longint'(term);
		if (acc < 0)
			acc = 0;
		return acc;
	endfunction

	function automatic longint rom_entry(longint unsigned i);
		longint unsigned j;
		longint unsigned q;
		longint unsigned r;
		longint v;
		j = i & longint'(TABLE_SIZE - 1);
		q = j / QUARTER;
		r = j % QUARTER;
		if (q[0])
			r = QUARTER - r;
		v = quarter_sine_q30(r);
		v = (v + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		if (q[1])
			v = -v;
		return v;
	endfunction

	function automatic longint floor_div_turn(longint n);
		if (n >= 0)
			return n / DEG_TURN;
		return -((-n + DEG_TURN - 1) / DEG_TURN);
	endfunction

	// interpolated table value at d degrees, d in 0..359
	function automatic fix_t deg_sine(int d);
		longint num;
		longint base;
		longint rem;
		longint v0;
		longint v1;
		longint v;
		longint one;
		num = longint'(d) * TABLE_SIZE;
		base = num / DEG_TURN;
		rem = num - base * DEG_TURN;
		v0 = rom_entry(base);
		v1 = rom_entry(base + 1);
		v = v0 + floor_div_turn((v1 - v0) * rem + DEG_HALF);
		one = longint'(1) <<< FRAC_BITS;
		if (v > one)
			v = one;
		else if (v < -one)
			v = -one;
		return fix_t'(v);
	endfunction

	function automatic half_tab_t build_half(int first);
		half_tab_t t;
		for (int d = 0; d < DEG_HALF; d++)
			t[d] = deg_sine(first + d);
		return t;
	endfunction

	localparam half_tab_t SINE_LO = build_half(0);
	localparam half_tab_t SINE_HI = build_half(DEG_HALF);

	function automatic fix_t deg_lookup(deg_t d);
		deg_t k;
		k = d - 9'(DEG_HALF);
		if (d >= 9'(DEG_HALF))
			return SINE_HI[k[7:0]];
		return SINE_LO[d[7:0]];
	endfunction

	function automatic fix_t sat_one(logic signed [17:0] v);
		if (v > ONE_Q)
			return ONE_FIX;
		if (v < -ONE_Q)
			return -ONE_FIX;
		return fix_t'(v);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/atuv_wrap.sv =====
// two-stage reduction of a signed degree count modulo 360
`default_nettype none

module atuv_wrap import atuv_pkg::*; (
	input  logic               clk,
	input  stage_en_t          en,
	input  logic signed [15:0] angle,
	output deg_t               deg
);

	logic [16:0] biased;
	logic [31:0] prod;
	logic [16:0] turns;
	logic [16:0] rem_full;

	logic [16:0] biased_s1;
	logic [7:0]  quo_s1;
	deg_t        deg_s2;

	assign biased = {angle[15], angle} + DEG_BIAS;
	// reciprocal multiply, quotient exact over the biased range
	assign prod = {15'd0, biased} * {16'd0, RECIP_360};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			biased_s1 <= biased;
			quo_s1 <= prod[RECIP_SHIFT +: 8];
		end
	end

	assign turns = {9'd0, quo_s1} * 17'(DEG_TURN);
	assign rem_full = biased_s1 - turns;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			deg_s2 <= rem_full[8:0];
		end
	end

	assign deg = deg_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/atuv_trig.sv =====
// sine and cosine lookup of a reduced angle from the per-degree tables
`default_nettype none

module atuv_trig import atuv_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  deg_t      deg,
	output fix_t      sin_val,
	output fix_t      cos_val
);

	deg_t deg_cos;
	fix_t sin_s3;
	fix_t cos_s3;

	// cosine is the sine a quarter turn ahead
	assign deg_cos = (deg >= 9'(DEG_TURN - DEG_QUAD)) ? deg - 9'(DEG_TURN - DEG_QUAD)
		: deg + 9'(DEG_QUAD);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sin_s3 <= deg_lookup(deg);
			cos_s3 <= deg_lookup(deg_cos);
		end
	end

	assign sin_val = sin_s3;
	assign cos_val = cos_s3;

endmodule

`default_nettype wire

// ===== hw/rtl/atuv_combine.sv =====
// products of the trig values, rounding and saturation into the output vector
`default_nettype none

module atuv_combine import atuv_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  fix_t      sin_yaw,
	input  fix_t      cos_yaw,
	input  fix_t      sin_pitch,
	input  fix_t      cos_pitch,
	output vec_t      vec
);

	logic signed [31:0] px_s4;
	logic signed [31:0] pz_s4;
	logic signed [16:0] ny_s4;
	vec_t               vec_s5;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			px_s4 <= sin_yaw * cos_pitch + MUL_ROUND;
			pz_s4 <= cos_yaw * cos_pitch + MUL_ROUND;
			ny_s4 <= -{sin_pitch[15], sin_pitch};
		end
	end

	// arithmetic shift floors, which with the half added rounds half up
	always_ff @(posedge clk) begin
		if (en.s5) begin
			vec_s5.dir_x <= sat_one(18'(px_s4 >>> FRAC_BITS));
			vec_s5.dir_y <= sat_one(18'(ny_s4));
			vec_s5.dir_z <= sat_one(18'(pz_s4 >>> FRAC_BITS));
		end
	end

	assign vec = vec_s5;

endmodule

`default_nettype wire

// ===== hw/rtl/angle_pair_to_unit_vector_top.sv =====
// top level: yaw/pitch degrees to a q1.14 unit direction vector
// an accepted request passes through stage registers s1 to s5, s5 being the output register
// throughput: one request per cycle; bubbles close up under output stall, stall
//   reaches the input only when all five stages hold requests
// reset clears the stage valid bits only; the sine tables are constants, no fill time
`default_nettype none

module angle_pair_to_unit_vector_top import atuv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic ang_valid,
	output logic ang_stall,
	input  ang_t ang,
	output logic vec_valid,
	input  logic vec_stall,
	output vec_t vec
);

	stage_en_t en;
	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      valid_s4;
	logic      valid_s5;

	deg_t yaw_red;
	deg_t pitch_red;
	fix_t sin_yaw;
	fix_t cos_yaw;
	fix_t sin_pitch;
	fix_t cos_pitch;

	// a stage loads when it is empty or its contents move on
	assign en.s5 = !valid_s5 || !vec_stall;
	assign en.s4 = !valid_s4 || en.s5;
	assign en.s3 = !valid_s3 || en.s4;
	assign en.s2 = !valid_s2 || en.s3;
	assign en.s1 = !valid_s1 || en.s2;

	assign ang_stall = !en.s1;
	assign vec_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1)
				valid_s1 <= ang_valid;
			if (en.s2)
				valid_s2 <= valid_s1;
			if (en.s3)
				valid_s3 <= valid_s2;
			if (en.s4)
				valid_s4 <= valid_s3;
			if (en.s5)
				valid_s5 <= valid_s4;
		end
	end

	atuv_wrap u_wrap_yaw (
		.clk   (clk),
		.en    (en),
		.angle (ang.yaw_deg),
		.deg   (yaw_red)
	);

	atuv_wrap u_wrap_pitch (
		.clk   (clk),
		.en    (en),
		.angle (ang.pitch_deg),
		.deg   (pitch_red)
	);

	atuv_trig u_trig_yaw (
		.clk     (clk),
		.en      (en),
		.deg     (yaw_red),
		.sin_val (sin_yaw),
		.cos_val (cos_yaw)
	);

	atuv_trig u_trig_pitch (
		.clk     (clk),
		.en      (en),
		.deg     (pitch_red),
		.sin_val (sin_pitch),
		.cos_val (cos_pitch)
	);

	atuv_combine u_combine (
		.clk       (clk),
		.en        (en),
		.sin_yaw   (sin_yaw),
		.cos_yaw   (cos_yaw),
		.sin_pitch (sin_pitch),
		.cos_pitch (cos_pitch),
		.vec       (vec)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ang_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && vec_stall))
		else $error("input stalled while the pipeline has room");

	a_reduced_in_turn: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (yaw_red < 9'(DEG_TURN) && pitch_red < 9'(DEG_TURN)))
		else $error("reduced angle outside one turn");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vec_valid |-> (vec.dir_x <= ONE_FIX && vec.dir_x >= -ONE_FIX
			&& vec.dir_y <= ONE_FIX && vec.dir_y >= -ONE_FIX
			&& vec.dir_z <= ONE_FIX && vec.dir_z >= -ONE_FIX))
		else $error("result component beyond unit magnitude");

	a_empty_never_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!vec_valid |-> !ang_stall)
		else $error("input stalled with an empty output register");

endmodule

`default_nettype wire

// ===== tb/tb_angle_pair_to_unit_vector_top.sv =====
// testbench for the yaw/pitch to unit direction vector block
module tb_angle_pair_to_unit_vector_top import atuv_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int BUSY_PCT = 38;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic ang_valid = 1'b0;
	logic ang_stall;
	ang_t ang = '0;
	logic vec_valid;
	logic vec_stall = 1'b0;
	vec_t vec;

	ang_t pending_angs[$];
	vec_t expected_vecs[$];
	longint sine_tab[TABLE_SIZE + 1];
	int idle_pct = BUSY_PCT;
	int mismatches = 0;
	int cycles = 0;

	angle_pair_to_unit_vector_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.ang_valid(ang_valid),
		.ang_stall(ang_stall),
		.ang(ang),
		.vec_valid(vec_valid),
		.vec_stall(vec_stall),
		.vec(vec)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint div_floor(longint num, longint den);
		if (num >= 0)
			return num / den;
		return -((-num + den - 1) / den);
	endfunction

	// taylor series for sin over one quadrant, result in q30
	function automatic longint quadrant_sine_q30(longint unsigned steps);
		longint unsigned arg;
		longint unsigned arg_sq;
		longint unsigned term;
		longint acc;
		arg = (64'd2 * HALF_PI_Q30 * steps + 64'(QUARTER)) / (64'd2 * 64'(QUARTER));
		arg_sq = (arg * arg) >> 30;
		term = arg;
		acc = longint'(arg);
		for (int k = 1; k <= 9; k++) begin
			term = ((term * arg_sq) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		return acc;
	endfunction

	function automatic longint table_value(int i);
		int pos;
		int quad;
		int steps;
		longint v;
		pos = i & (TABLE_SIZE - 1);
		quad = pos / QUARTER;
		steps = pos % QUARTER;
		if (quad % 2 == 1)
			steps = QUARTER - steps;
		v = quadrant_sine_q30(longint'(steps));
		v = (v + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		if (quad >= 2)
			v = -v;
		return v;
	endfunction

	// position deg*TABLE_SIZE/360, floored index plus offset, fraction in 1/360 steps
	function automatic longint interp_sine(longint deg, longint offset);
		longint num;
		longint base;
		longint frac;
		longint v0;
		longint v1;
		int idx;
		num = deg * TABLE_SIZE;
		base = div_floor(num, DEG_TURN);
		frac = num - base * DEG_TURN;
		idx = int'((base + offset) & longint'(TABLE_SIZE - 1));
		v0 = sine_tab[idx];
		v1 = sine_tab[idx + 1];
		return v0 + div_floor((v1 - v0) * frac + DEG_HALF, DEG_TURN);
	endfunction

	function automatic longint clamp_unit(longint v);
		longint one;
		one = longint'(1) << FRAC_BITS;
		if (v > one)
			return one;
		if (v < -one)
			return -one;
		return v;
	endfunction

	function automatic longint fix_mul(longint a, longint b);
		return div_floor(a * b + (longint'(1) << (FRAC_BITS - 1)), longint'(1) << FRAC_BITS);
	endfunction

	function automatic vec_t predict_direction(ang_t a);
		longint sin_yaw;
		longint cos_yaw;
		longint sin_pitch;
		longint cos_pitch;
		vec_t r;
		sin_yaw = clamp_unit(interp_sine(longint'(a.yaw_deg), 0));
		cos_yaw = clamp_unit(interp_sine(longint'(a.yaw_deg), QUARTER));
		sin_pitch = clamp_unit(interp_sine(longint'(a.pitch_deg), 0));
		cos_pitch = clamp_unit(interp_sine(longint'(a.pitch_deg), QUARTER));
		r.dir_x = fix_t'(clamp_unit(fix_mul(sin_yaw, cos_pitch)));
		r.dir_y = fix_t'(clamp_unit(-sin_pitch));
		r.dir_z = fix_t'(clamp_unit(fix_mul(cos_yaw, cos_pitch)));
		return r;
	endfunction

	function automatic logic signed [15:0] random_angle();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(1440) - 720);
			// near the quadrant and octant points
			2: return 16'(45 * ($urandom_range(64) - 32) + $urandom_range(2) - 1);
			default: begin
				if ($urandom_range(1))
					return 16'(32767 - $urandom_range(400));
				return 16'(-32768 + $urandom_range(400));
			end
		endcase
	endfunction

	task automatic queue_request(int yaw, int pitch);
		ang_t a;
		a.yaw_deg = 16'(yaw);
		a.pitch_deg = 16'(pitch);
		pending_angs.push_back(a);
	endtask

	task automatic queue_random(int count);
		ang_t a;
		for (int n = 0; n < count; n++) begin
			a.yaw_deg = random_angle();
			a.pitch_deg = random_angle();
			pending_angs.push_back(a);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_angs.size() != 0 || ang_valid || expected_vecs.size() != 0);
	endtask

	// sender: a request is held until taken, prediction made at acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (ang_valid && !ang_stall)
				expected_vecs.push_back(predict_direction(ang));
			if (!ang_valid || !ang_stall) begin
				if (pending_angs.size() != 0 && $urandom_range(99) >= idle_pct) begin
					ang_valid <= 1'b1;
					ang <= pending_angs.pop_front();
				end else begin
					ang_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall, check each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (vec_valid && !vec_stall) begin
				if (expected_vecs.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
						vec.dir_x, vec.dir_y, vec.dir_z);
				end else begin
					vec_t e;
					e = expected_vecs.pop_front();
					if (vec.dir_x !== e.dir_x) begin
						mismatches++;
						$display("%0t: dir_x expected %0d actual %0d", $time, e.dir_x, vec.dir_x);
					end
					if (vec.dir_y !== e.dir_y) begin
						mismatches++;
						$display("%0t: dir_y expected %0d actual %0d", $time, e.dir_y, vec.dir_y);
					end
					if (vec.dir_z !== e.dir_z) begin
						mismatches++;
						$display("%0t: dir_z expected %0d actual %0d", $time, e.dir_z, vec.dir_z);
					end
				end
			end
			vec_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i <= TABLE_SIZE; i++)
			sine_tab[i] = table_value(i);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// extremes, quadrant points, wrap and negative floor cases, exact table steps
		queue_request(0, 0);
		queue_request(90, 0);
		queue_request(180, 0);
		queue_request(270, 0);
		queue_request(360, 360);
		queue_request(-90, 0);
		queue_request(0, 90);
		queue_request(0, -90);
		queue_request(45, 45);
		queue_request(-45, -45);
		queue_request(1, 1);
		queue_request(-1, -1);
		queue_request(359, 359);
		queue_request(-359, 179);
		queue_request(32767, 32767);
		queue_request(-32768, -32768);
		queue_request(32767, -32768);
		queue_request(-32768, 32767);
		queue_request(89, 91);
		queue_request(-181, 271);
		queue_request(22, 67);
		queue_request(30, 60);
		queue_random(500);
		// sender holds off until every result is back
		wait_drained();

		// stretch with no idling or stalls on either side
		idle_pct = 0;
		queue_random(250);
		wait_drained();
		idle_pct = BUSY_PCT;
		queue_random(330);
		wait_drained();

		repeat (20) @(negedge clk);
		if (expected_vecs.size() != 0) begin
			mismatches++;
			$display("%0t: %0d results never arrived", $time, expected_vecs.size());
		end
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
